FILE: rtl/core/cbnm_pkg.sv
// Shared types and constants for the conservative backfill node map.
package cbnm_pkg;

  // Fixed field widths
  localparam int unsigned CNT16_W   = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PROC_W    = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Divider widths: dividend is procs plus divisor minus one
  localparam int unsigned DVD_W  = PROC_W + 1;
  localparam int unsigned DVS_W  = CNT16_W;
  localparam int unsigned STEP_W = $clog2(DVD_W);

  // Request kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_RUNNING = 2'd1;
  localparam logic [1:0] KIND_PENDING = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPUS_PER_NODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_PER_NODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_PER_NODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_TIME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PART_NODES    = 3'd4;

  // Result status codes
  typedef enum logic [3:0] {
    STS_STARTED  = 4'd0,
    STS_ADDED    = 4'd1,
    STS_ZERO     = 4'd2,
    STS_FULL     = 4'd3,
    STS_HELD     = 4'd4,
    STS_TIME     = 4'd5,
    STS_NODES    = 4'd6,
    STS_LOCALITY = 4'd7,
    STS_FIFO     = 4'd8,
    STS_BACKFILL = 4'd9,
    STS_RESERVED = 4'd10,
    STS_NO_SLOT  = 4'd11,
    STS_IGNORED  = 4'd12
  } cbnm_status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_DIV,
    ST_FILTER,
    ST_SCAN,
    ST_SUB,
    ST_FINISH
  } cbnm_state_e;

  // Divider command and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } cbnm_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } cbnm_div_rsp_t;

endpackage

FILE: rtl/core/cbnm_div.sv
// Restoring divider, one quotient bit per cycle.
module cbnm_div import cbnm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cbnm_div_req_t req_i,
  output cbnm_div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    diff;
  logic              ge;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  // Step counter and completion pulse
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Load operands, then advance remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/core/conservative_backfill_node_map.sv
// Conservative backfill node map: sequencer, slot memory and filters.
// Start and running requests pass through the simple and finish states, one request at a time.
// Pending requests divide, then filter; when no filter decides, the map slots are
//   scanned and nodes reserved from the slots after the last short one (one slot per cycle).
// The map has 129 slots by default; a new request is taken while
//   the previous result still waits at the output register.
// Reset clears control state and counts; slot contents are undefined until written.
module conservative_backfill_node_map import cbnm_pkg::*; #(
  parameter int unsigned MAX_RUNNING = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           kind_i,
  input  logic [CNT16_W-1:0]   node_count_i,
  input  logic [WORD_W-1:0]    job_tag_i,
  input  logic [WORD_W-1:0]    priority_req_i,
  input  logic                 has_time_limit_i,
  input  logic [WORD_W-1:0]    time_limit_i,
  input  logic [PROC_W-1:0]    proc_count_i,
  input  logic [CNT16_W-1:0]   procs_per_node_i,
  input  logic [WORD_W-1:0]    mem_needed_i,
  input  logic [WORD_W-1:0]    disk_needed_i,
  input  logic                 placement_restricted_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           status_o,
  output logic [WORD_W-1:0]    job_tag_out_o,
  output logic [WORD_W-1:0]    new_priority_o,
  output logic [CNT16_W-1:0]   nodes_needed_o
);

  localparam int unsigned MAP_DEPTH = MAX_RUNNING + 1;
  localparam int unsigned IDX_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(MAP_DEPTH + 1);

  // Configuration registers
  logic [CNT16_W-1:0] cpn_q;
  logic [WORD_W-1:0]  mpn_q, dpn_q, ptl_q;
  logic [CNT16_W-1:0] pnl_q;

  // Control state
  cbnm_state_e        state_q, state_d;
  logic [CNT_W-1:0]   map_entries_q;
  logic [CNT16_W-1:0] free_now_q, running_total_q;
  logic [WORD_W-1:0]  lead_priority_q;
  logic               lead_set_q, pass_stopped_q;
  logic               out_valid_q;

  // Latched request
  logic [1:0]         kind_q;
  logic [CNT16_W-1:0] cnt_q;
  logic [WORD_W-1:0]  tag_q, prio_q, tl_q, memn_q, diskn_q;
  logic               has_tl_q, restr_q;
  logic [CNT16_W-1:0] ppn_q;

  // Working registers
  logic [CNT16_W-1:0] need_q;
  cbnm_status_e       res_status_q;
  logic [WORD_W-1:0]  res_prio_q;
  logic [IDX_W-1:0]   ptr_q, last_q;
  logic               found_q;

  // Output registers
  cbnm_status_e       out_status_q;
  logic [WORD_W-1:0]  out_tag_q, out_prio_q;
  logic [CNT16_W-1:0] out_need_q;

  // Slot memory
  logic [CNT16_W-1:0] free_map [MAP_DEPTH];
  logic [CNT16_W-1:0] rd_data_q;
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [CNT16_W-1:0] wr_data;

  // Divider
  cbnm_div_req_t      div_req;
  cbnm_div_rsp_t      div_rsp;
  logic [CNT16_W-1:0] cdiv;

  logic               in_fire, out_free, finishing;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign finishing = (state_q == ST_FINISH) && out_free;

  // Zero cpus per node counts as one
  assign cdiv = (cpn_q == '0) ? CNT16_W'(1) : cpn_q;

  assign div_req.start    = in_fire && (kind_i == KIND_PENDING);
  assign div_req.dividend = {1'b0, proc_count_i} + DVD_W'(cdiv) - DVD_W'(1);
  assign div_req.divisor  = cdiv;

  cbnm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Raise to the requested count and saturate
  logic [DVD_W-1:0]   need_max;
  logic [CNT16_W-1:0] need_sat;
  assign need_max = (div_rsp.quotient < DVD_W'(cnt_q)) ? DVD_W'(cnt_q) : div_rsp.quotient;
  assign need_sat = (need_max > DVD_W'({CNT16_W{1'b1}})) ? {CNT16_W{1'b1}}
                                                         : need_max[CNT16_W-1:0];

  // Running total with saturation
  logic [CNT16_W:0]   run_sum;
  logic [CNT16_W-1:0] run_sat;
  logic               map_full;
  assign run_sum  = {1'b0, running_total_q} + {1'b0, cnt_q};
  assign run_sat  = run_sum[CNT16_W] ? {CNT16_W{1'b1}} : run_sum[CNT16_W-1:0];
  assign map_full = (map_entries_q >= CNT_W'(MAP_DEPTH));

  // Start, running and unknown requests
  cbnm_status_e simple_status;
  always_comb begin
    simple_status = STS_IGNORED;
    if (kind_q == KIND_START) begin
      simple_status = STS_STARTED;
    end else if (kind_q == KIND_RUNNING) begin
      if (cnt_q == '0) begin
        simple_status = STS_ZERO;
      end else if (map_full) begin
        simple_status = STS_FULL;
      end else begin
        simple_status = STS_ADDED;
      end
    end
  end

  // Pending request filters, in priority order
  cbnm_status_e flt_status;
  logic         flt_done, flt_stop, flt_lead;
  always_comb begin
    flt_status = STS_IGNORED;
    flt_done   = 1'b1;
    flt_stop   = 1'b0;
    flt_lead   = 1'b0;
    if (pass_stopped_q) begin
      flt_status = STS_IGNORED;
    end else if (prio_q == '0) begin
      flt_status = STS_HELD;
    end else if (has_tl_q && (tl_q > ptl_q)) begin
      flt_status = STS_TIME;
    end else if (need_q > pnl_q) begin
      flt_status = STS_NODES;
    end else if (restr_q || (ppn_q > cpn_q) || (memn_q > mpn_q) || (diskn_q > dpn_q)) begin
      flt_status = STS_LOCALITY;
      flt_stop   = 1'b1;
    end else if (!lead_set_q && (need_q <= free_now_q)) begin
      flt_status = STS_FIFO;
      flt_stop   = 1'b1;
    end else begin
      flt_lead = !lead_set_q;
      if (map_entries_q == '0) begin
        flt_status = STS_NO_SLOT;
      end else begin
        flt_done = 1'b0;
      end
    end
  end

  // Scan and reserve bookkeeping on the shared compare
  logic             lt, found_now, last_entry;
  logic [IDX_W-1:0] last_now;
  logic [CNT_W-1:0] start_now;
  logic [IDX_W-1:0] ptr_next;
  logic [WORD_W-1:0] promo_prio;
  assign lt         = (rd_data_q < need_q);
  assign found_now  = found_q || lt;
  assign last_now   = lt ? ptr_q : last_q;
  assign start_now  = CNT_W'(last_now) + CNT_W'(1);
  assign last_entry = (CNT_W'(ptr_q) == (map_entries_q - CNT_W'(1)));
  assign ptr_next   = ptr_q + IDX_W'(1);
  assign promo_prio = (lead_priority_q == {WORD_W{1'b1}}) ? lead_priority_q
                                                          : lead_priority_q + WORD_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (kind_i == KIND_PENDING) ? ST_DIV : ST_SIMPLE;
        end
      end
      ST_SIMPLE: state_d = ST_FINISH;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FILTER;
        end
      end
      ST_FILTER: state_d = flt_done ? ST_FINISH : ST_SCAN;
      ST_SCAN: begin
        if (last_entry) begin
          if (!found_now || (start_now == map_entries_q)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SUB;
          end
        end
      end
      ST_SUB: begin
        if (last_entry) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory port control
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SIMPLE: begin
        if ((kind_q == KIND_START) && (cnt_q != '0)) begin
          wr_en   = 1'b1;
          wr_data = cnt_q;
        end else if ((kind_q == KIND_RUNNING) && (cnt_q != '0) && !map_full) begin
          wr_en   = 1'b1;
          wr_addr = map_entries_q[IDX_W-1:0];
          wr_data = run_sat;
        end
      end
      ST_FILTER: rd_en = !flt_done;
      ST_SCAN: begin
        if (!last_entry) begin
          rd_en   = 1'b1;
          rd_addr = ptr_next;
        end else if (found_now && (start_now != map_entries_q)) begin
          rd_en   = 1'b1;
          rd_addr = start_now[IDX_W-1:0];
        end
      end
      ST_SUB: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rd_data_q - need_q;
        if (!last_entry) begin
          rd_en   = 1'b1;
          rd_addr = ptr_next;
        end
      end
      ST_DIV, ST_FINISH: ;
      default: ;
    endcase
  end

  // Slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      free_map[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= free_map[rd_addr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpn_q <= CNT16_W'(1);
      mpn_q <= '0;
      dpn_q <= '0;
      ptl_q <= {WORD_W{1'b1}};
      pnl_q <= {CNT16_W{1'b1}};
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CPUS_PER_NODE: cpn_q <= cfg_data_i[CNT16_W-1:0];
        CFG_MEM_PER_NODE:  mpn_q <= cfg_data_i;
        CFG_DISK_PER_NODE: dpn_q <= cfg_data_i;
        CFG_PART_TIME:     ptl_q <= cfg_data_i;
        CFG_PART_NODES:    pnl_q <= cfg_data_i[CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  // Map and pass control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      map_entries_q   <= '0;
      free_now_q      <= '0;
      running_total_q <= '0;
      lead_priority_q <= '0;
      lead_set_q      <= 1'b0;
      pass_stopped_q  <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (out_valid_q && !out_ready_i) || finishing;
      if (state_q == ST_SIMPLE) begin
        if (kind_q == KIND_START) begin
          map_entries_q   <= (cnt_q != '0) ? CNT_W'(1) : '0;
          free_now_q      <= cnt_q;
          running_total_q <= cnt_q;
          lead_priority_q <= '0;
          lead_set_q      <= 1'b0;
          pass_stopped_q  <= 1'b0;
        end else if ((kind_q == KIND_RUNNING) && (cnt_q != '0) && !map_full) begin
          running_total_q <= run_sat;
          map_entries_q   <= map_entries_q + CNT_W'(1);
        end
      end
      if (state_q == ST_FILTER) begin
        if (flt_stop) begin
          pass_stopped_q <= 1'b1;
        end
        if (flt_lead) begin
          lead_set_q      <= 1'b1;
          lead_priority_q <= prio_q;
        end
      end
      if ((state_q == ST_SCAN) && last_entry && !found_now) begin
        pass_stopped_q <= 1'b1;
      end
    end
  end

  // Request latch, working and output registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= kind_i;
      cnt_q      <= node_count_i;
      tag_q      <= job_tag_i;
      prio_q     <= priority_req_i;
      has_tl_q   <= has_time_limit_i;
      tl_q       <= time_limit_i;
      ppn_q      <= procs_per_node_i;
      memn_q     <= mem_needed_i;
      diskn_q    <= disk_needed_i;
      restr_q    <= placement_restricted_i;
      need_q     <= '0;
      res_prio_q <= '0;
    end
    unique case (state_q)
      ST_SIMPLE: res_status_q <= simple_status;
      ST_DIV: begin
        if (div_rsp.done) begin
          need_q <= need_sat;
        end
      end
      ST_FILTER: begin
        res_status_q <= flt_status;
        ptr_q        <= '0;
        found_q      <= 1'b0;
        last_q       <= '0;
      end
      ST_SCAN: begin
        found_q <= found_now;
        last_q  <= last_now;
        if (!last_entry) begin
          ptr_q <= ptr_next;
        end else if (!found_now) begin
          res_status_q <= STS_BACKFILL;
          res_prio_q   <= promo_prio;
        end else if (start_now == map_entries_q) begin
          res_status_q <= STS_NO_SLOT;
        end else begin
          ptr_q <= start_now[IDX_W-1:0];
        end
      end
      ST_SUB: begin
        ptr_q <= ptr_next;
        if (last_entry) begin
          res_status_q <= STS_RESERVED;
        end
      end
      ST_IDLE, ST_FINISH: ;
      default: ;
    endcase
    if (finishing) begin
      out_status_q <= res_status_q;
      out_tag_q    <= tag_q;
      out_prio_q   <= res_prio_q;
      out_need_q   <= need_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign job_tag_out_o  = out_tag_q;
  assign new_priority_o = out_prio_q;
  assign nodes_needed_o = out_need_q;

  // Sequencer checks
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after accepting a request");

  a_entries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_entries_q <= CNT_W'(MAP_DEPTH))
    else $error("map entry count beyond depth");

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUB) |-> (CNT_W'(ptr_q) < map_entries_q))
    else $error("reserve pass outside filled slots");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_backfill_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (res_status_q == STS_BACKFILL)) |-> pass_stopped_q)
    else $error("promotion did not stop the pass");

endmodule
